// ----- hdl/vlmq_pkg.sv -----
// Shared types, constants and helper functions of the message queue space manager.
package vlmq_pkg;

  // Buffer geometry.
  localparam int BUF_BYTES    = 4096;
  localparam int HEADER_BYTES = 4;
  localparam int ALIGN_BYTES  = 4;
  localparam int COUNT_MAX    = 1023;

  // Headers always start on a four-byte boundary, so the header store holds one entry per slot.
  localparam int SLOT_SHIFT = 2;
  localparam int RAM_DEPTH  = BUF_BYTES >> SLOT_SHIFT;
  localparam int ADDR_W     = $clog2(RAM_DEPTH);
  localparam int POS_W      = ADDR_W + SLOT_SHIFT;

  // Field and datapath widths.
  localparam int HDR_W  = 13;
  localparam int QB_W   = 13;
  localparam int SIZE_W = 12;
  localparam int CNT_W  = 10;
  localparam int OFF_W  = 14;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_PEEK  = 2'd1,
    REQ_PURGE = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ZERO  = 2'd3
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [OFF_W-1:0] a;
    logic [OFF_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [HDR_W-1:0]  wdata;
  } ram_req_t;

  typedef struct packed {
    status_e           status;
    logic [SIZE_W-1:0] data_offset;
    logic [SIZE_W-1:0] head_size;
    logic [CNT_W-1:0]  msg_count;
  } result_t;

  // Bytes taken by a message of n payload bytes: header plus payload padded to the alignment.
  function automatic logic [OFF_W-1:0] hdr_span(input logic [OFF_W-1:0] n);
    logic [OFF_W-1:0] t;
    t = n + OFF_W'(HEADER_BYTES + ALIGN_BYTES - 1);
    return t & ~OFF_W'(ALIGN_BYTES - 1);
  endfunction

endpackage

// ----- hdl/vlmq_ram.sv -----
// Generic single-port RAM with registered read data.
module vlmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/vlmq_alu.sv -----
// Shared adder and subtractor used by the arithmetic steps of the sequencer.
module vlmq_alu
  import vlmq_pkg::*;
(
  input  alu_req_t         req_i,
  output logic [OFF_W-1:0] res_o,
  output logic             borrow_o
);

  logic [OFF_W:0] sum;

  always_comb begin
    unique case (req_i.op)
      ALU_ADD: sum = {1'b0, req_i.a} + {1'b0, req_i.b};
      ALU_SUB: sum = {1'b0, req_i.a} - {1'b0, req_i.b};
      default: sum = '0;
    endcase
  end

  // For a subtraction the top bit is set exactly when a is less than b.
  assign res_o    = sum[OFF_W-1:0];
  assign borrow_o = sum[OFF_W];

endmodule

// ----- hdl/vlmq_ctrl.sv -----
// Request sequencer holding the ring pointers, message count and per-request work registers.
module vlmq_ctrl
  import vlmq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [SIZE_W-1:0] msg_size_i,
  input  logic [QB_W-1:0]   q_bytes_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output result_t           res_o,
  output ram_req_t          ram_req_o,
  input  logic [HDR_W-1:0]  ram_rdata_i,
  output alu_req_t          alu_req_o,
  input  logic [OFF_W-1:0]  alu_res_i,
  input  logic              alu_borrow_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_P_EMPTY, S_P_OFF, S_P_HD, S_P_FIT, S_P_GAP, S_P_GN, S_P_HN,
    S_P_MK, S_P_COMMIT, S_PK, S_G_STEP, S_G_NH4, S_G_CMP, S_G_RD, S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [OFF_W-1:0]  need_q, need_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [OFF_W-1:0]  acc_q, acc_d;
  logic [POS_W-1:0]  head_q, head_d;
  logic [POS_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  status_e           status_q, status_d;
  logic [SIZE_W-1:0] doff_q, doff_d;
  logic [SIZE_W-1:0] hsize_q, hsize_d;

  logic [OFF_W-1:0]  q_ext, head_ext, tail_ext, rd_ext;

  assign q_ext    = OFF_W'(q_bytes_i);
  assign head_ext = OFF_W'(head_q);
  assign tail_ext = OFF_W'(tail_q);
  assign rd_ext   = OFF_W'(ram_rdata_i);

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    need_d      = need_q;
    off_d       = off_q;
    acc_d       = acc_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    status_d    = status_q;
    doff_d      = doff_q;
    hsize_d     = hsize_q;
    res_valid_o = 1'b0;
    ram_req_o   = '{we: 1'b0, addr: head_q[POS_W-1:SLOT_SHIFT], wdata: '0};
    alu_req_o   = '{op: ALU_ADD, a: '0, b: '0};

    unique case (state_q)
      S_IDLE: begin
        // The header read for the new request starts in the accept cycle.
        if (req_type_i == REQ_PUT) begin
          ram_req_o.addr = tail_q[POS_W-1:SLOT_SHIFT];
        end
        if (in_valid_i) begin
          status_d = ST_OK;
          doff_d   = '0;
          hsize_d  = '0;
          size_d   = msg_size_i;
          need_d   = hdr_span(OFF_W'(msg_size_i));
          unique case (req_e'(req_type_i))
            REQ_PUT: begin
              if (msg_size_i == '0) begin
                status_d = ST_ZERO;
                state_d  = S_DONE;
              end else if (count_q == '0) begin
                state_d = S_P_EMPTY;
              end else begin
                state_d = S_P_OFF;
              end
            end
            REQ_PEEK: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                state_d = S_PK;
              end
            end
            REQ_PURGE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                state_d = S_G_STEP;
              end
            end
            REQ_NOP: state_d = S_DONE;
            default: state_d = S_DONE;
          endcase
        end
      end

      S_P_EMPTY: begin
        head_d    = '0;
        alu_req_o = '{op: ALU_SUB, a: q_ext, b: need_q};
        if (alu_borrow_i) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          off_d   = '0;
          state_d = S_P_COMMIT;
        end
      end

      S_P_OFF: begin
        alu_req_o = '{op: ALU_ADD, a: tail_ext, b: hdr_span(rd_ext)};
        off_d     = alu_res_i;
        state_d   = S_P_HD;
      end

      S_P_HD: begin
        alu_req_o = '{op: ALU_SUB, a: head_ext, b: off_q};
        acc_d     = alu_res_i;
        state_d   = alu_borrow_i ? S_P_GAP : S_P_FIT;
      end

      S_P_FIT: begin
        alu_req_o = '{op: ALU_SUB, a: acc_q, b: need_q};
        if (alu_borrow_i) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          state_d = S_P_COMMIT;
        end
      end

      S_P_GAP: begin
        alu_req_o = '{op: ALU_SUB, a: q_ext, b: off_q};
        acc_d     = alu_borrow_i ? '0 : alu_res_i;
        state_d   = S_P_GN;
      end

      S_P_GN: begin
        alu_req_o = '{op: ALU_SUB, a: acc_q, b: need_q};
        state_d   = alu_borrow_i ? S_P_HN : S_P_COMMIT;
      end

      S_P_HN: begin
        alu_req_o = '{op: ALU_SUB, a: head_ext, b: need_q};
        if (alu_borrow_i) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          state_d = S_P_MK;
        end
      end

      S_P_MK: begin
        // A wrap marker goes in only when the tail gap is larger than one header.
        ram_req_o = '{we: (acc_q > OFF_W'(HEADER_BYTES)),
                      addr: off_q[POS_W-1:SLOT_SHIFT], wdata: '0};
        off_d     = '0;
        state_d   = S_P_COMMIT;
      end

      S_P_COMMIT: begin
        if (count_q >= CNT_W'(COUNT_MAX)) begin
          status_d = ST_FULL;
        end else begin
          tail_d    = off_q[POS_W-1:0];
          count_d   = count_q + CNT_W'(1);
          ram_req_o = '{we: 1'b1, addr: off_q[POS_W-1:SLOT_SHIFT],
                        wdata: HDR_W'(size_q)};
          doff_d    = off_q[SIZE_W-1:0] + SIZE_W'(HEADER_BYTES);
        end
        state_d = S_DONE;
      end

      S_PK: begin
        hsize_d = ram_rdata_i[SIZE_W-1:0];
        doff_d  = head_q[SIZE_W-1:0] + SIZE_W'(HEADER_BYTES);
        state_d = S_DONE;
      end

      S_G_STEP: begin
        alu_req_o = '{op: ALU_ADD, a: head_ext, b: hdr_span(rd_ext)};
        off_d     = alu_res_i;
        count_d   = count_q - CNT_W'(1);
        state_d   = S_G_NH4;
      end

      S_G_NH4: begin
        alu_req_o = '{op: ALU_ADD, a: off_q, b: OFF_W'(HEADER_BYTES)};
        acc_d     = alu_res_i;
        state_d   = S_G_CMP;
      end

      S_G_CMP: begin
        alu_req_o = '{op: ALU_SUB, a: acc_q, b: q_ext};
        if (!alu_borrow_i) begin
          head_d  = '0;
          state_d = S_DONE;
        end else if (count_q != '0) begin
          ram_req_o.addr = off_q[POS_W-1:SLOT_SHIFT];
          state_d        = S_G_RD;
        end else begin
          head_d  = off_q[POS_W-1:0];
          state_d = S_DONE;
        end
      end

      S_G_RD: begin
        // A zero-size header at the new head is a wrap marker.
        head_d  = (ram_rdata_i == '0) ? '0 : off_q[POS_W-1:0];
        state_d = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign res_o      = '{status: status_q, data_offset: doff_q, head_size: hsize_q,
                        msg_count: count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      size_q   <= '0;
      need_q   <= '0;
      off_q    <= '0;
      acc_q    <= '0;
      status_q <= ST_OK;
      doff_q   <= '0;
      hsize_q  <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      size_q   <= size_d;
      need_q   <= need_d;
      off_q    <= off_d;
      acc_q    <= acc_d;
      status_q <= status_d;
      doff_q   <= doff_d;
      hsize_q  <= hsize_d;
    end
  end

endmodule

// ----- hdl/variable_length_message_queue_unit.sv -----
// Space manager for a ring buffer of variable-length messages. Every message sits behind a
// four-byte size header with its payload padded to four bytes. A put transaction asks for room
// and returns the payload offset or full; when the tail gap is too small a zero-size wrap marker
// is written there (if the gap exceeds a header) and the message goes to offset 0. A peek
// returns the head message's payload offset and size, and a purge frees the head message,
// skipping wrap markers. Empty peeks and purges report empty, and a zero-size put is rejected.
// Every transaction yields exactly one result. The block handles one request at a time, and its
// sequencing is set by the single shared adder/subtractor, which the sequencer steps through
// one comparison per cycle, and by the one-port header store, whose read data is registered.
// The result sits in an output register, so the sequencer starts the next request while the
// previous result waits to be taken. The buffer size register may be written at any time the
// block is idle; sizes above 4096 act as 4096.
module variable_length_message_queue_unit
  import vlmq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Request channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [SIZE_W-1:0] msg_size_i,
  // Result channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [SIZE_W-1:0] data_offset_o,
  output logic [SIZE_W-1:0] head_size_o,
  output logic [CNT_W-1:0]  msg_count_o,
  // Configuration channel for the buffer size register.
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [QB_W-1:0]   queue_bytes_i
);

  logic [QB_W-1:0] queue_bytes_q;
  logic [QB_W-1:0] q_eff;

  result_t  res;
  logic     res_valid;
  logic     res_ready;
  ram_req_t ram_req;
  logic [HDR_W-1:0] ram_rdata;
  alu_req_t alu_req;
  logic [OFF_W-1:0] alu_res;
  logic     alu_borrow;

  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  // The configuration register is always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_bytes_q <= QB_W'(BUF_BYTES);
    end else if (cfg_valid_i && cfg_ready_o) begin
      queue_bytes_q <= queue_bytes_i;
    end
  end

  // The usable size never exceeds the physical buffer.
  assign q_eff = (queue_bytes_q > QB_W'(BUF_BYTES)) ? QB_W'(BUF_BYTES) : queue_bytes_q;

  vlmq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .msg_size_i   (msg_size_i),
    .q_bytes_i    (q_eff),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata),
    .alu_req_o    (alu_req),
    .alu_res_i    (alu_res),
    .alu_borrow_i (alu_borrow)
  );

  vlmq_alu u_alu (
    .req_i    (alu_req),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  // Header store: one size entry per four-byte slot of the buffer.
  vlmq_ram #(
    .WIDTH (HDR_W),
    .DEPTH (RAM_DEPTH)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  // Output register: a new result may be loaded when the slot is empty or being emptied.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign data_offset_o = out_q.data_offset;
  assign head_size_o   = out_q.head_size;
  assign msg_count_o   = out_q.msg_count;

endmodule

// ----- hdl/vlmq_checker.sv -----
// Port-level assertions for the message queue space manager and their binding to the top level.
module vlmq_checker
  import vlmq_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [1:0]        status_o,
  input logic [SIZE_W-1:0] data_offset_o,
  input logic [SIZE_W-1:0] head_size_o,
  input logic [CNT_W-1:0]  msg_count_o
);

  // A result held under stall stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Every request leaves the idle state on acceptance, so the block is busy right after an acceptance.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted back to back");

  // Failed requests carry neither an offset nor a size.
  a_fail_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (data_offset_o == '0) && (head_size_o == '0))
    else $error("failed request reports an offset or size");

  // An empty report means nothing is stored.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> (msg_count_o == '0))
    else $error("empty status with messages stored");

  // Payload offsets are always four-byte aligned.
  a_offset_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (data_offset_o[1:0] == 2'b00))
    else $error("unaligned payload offset");

endmodule

bind variable_length_message_queue_unit vlmq_checker u_vlmq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .data_offset_o (data_offset_o),
  .head_size_o   (head_size_o),
  .msg_count_o   (msg_count_o)
);
